>>> rtl/edc_pkg.sv
// Shared types and constants for the 2x2 eigen decomposition block.
// No dependencies; edc_norm and the top level in rtl/ import this package.
`default_nettype none
package edc_pkg;

  localparam int DW      = 32;          // matrix and eigenvalue word
  localparam int VFB     = 30;          // vector fraction bits
  localparam int CW      = 36;          // raw vector component width
  localparam int MW      = VFB + 1;     // normalized magnitude width
  localparam int LW      = 36;          // unsaturated eigenvalue width
  localparam int IMW     = 33;          // unsaturated imaginary width
  localparam int DISC_W  = 68;          // |discriminant| radicand width
  localparam int SW      = DISC_W / 2;  // rounded root width
  localparam int SUM_W   = 2 * MW + 2;  // sum of four squares
  localparam int NW      = SUM_W / 2;   // vector norm width
  localparam int NUM_W   = MW + VFB + 1;
  localparam int NORM_LAT = 5;

  typedef struct packed {
    logic signed [DW-1:0] m11;
    logic signed [DW-1:0] m21;
    logic signed [DW-1:0] m12;
    logic signed [DW-1:0] m22;
  } edc_in_t;

  typedef struct packed {
    logic signed [DW-1:0] lam1_re;
    logic        [DW-2:0] lam1_im;
    logic signed [DW-1:0] lam2_re;
    logic signed [DW-1:0] lam2_im;
    logic signed [DW-1:0] vec1_x_re;
    logic signed [DW-1:0] vec1_x_im;
    logic signed [DW-1:0] vec1_y_re;
    logic signed [DW-1:0] vec1_y_im;
    logic signed [DW-1:0] vec2_x_re;
    logic signed [DW-1:0] vec2_x_im;
    logic signed [DW-1:0] vec2_y_re;
    logic signed [DW-1:0] vec2_y_im;
  } edc_out_t;

  typedef logic signed [CW-1:0] comp_t;
  typedef comp_t [3:0] vec_t;        // [0]=x_re [1]=x_im [2]=y_re [3]=y_im
  typedef logic [MW-1:0] mag_t;

  typedef struct packed {
    logic signed [LW-1:0] l1;
    logic signed [LW-1:0] l2;
    logic        [IMW-1:0] im;
  } lam_t;

endpackage
`default_nettype wire

>>> rtl/edc_isqrt.sv
// Pipelined integer square root, one result bit per stage, optional rounding.
// Standalone; carries a valid bit and a tag alongside the data.
`default_nettype none
module edc_isqrt #(
  parameter int IN_W  = 64,
  parameter int LANES = 1,
  parameter int TW    = 1,
  parameter bit ROUND = 1'b0
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  input  logic [LANES-1:0][IN_W-1:0]         in_rad,
  input  logic [TW-1:0]                      in_tag,
  output logic                               out_valid,
  output logic [LANES-1:0][IN_W/2-1:0]       out_root,
  output logic [TW-1:0]                      out_tag
);
  localparam int RW = IN_W / 2;

  logic [LANES-1:0][IN_W-1:0] rem_s  [RW];
  logic [LANES-1:0][RW-1:0]   root_s [RW];
  logic [TW-1:0]              tag_s  [RW];
  logic                       vld    [RW];

  for (genvar k = 0; k < RW; k++) begin : g_stage
    localparam int B = RW - 1 - k;
    logic [LANES-1:0][IN_W-1:0] src_rem;
    logic [LANES-1:0][RW-1:0]   src_root;
    logic [TW-1:0]              src_tag;
    logic                       src_vld;
    logic [LANES-1:0][IN_W-1:0] trial;

    if (k == 0) begin : g_first
      assign src_rem  = in_rad;
      assign src_root = '0;
      assign src_tag  = in_tag;
      assign src_vld  = in_valid;
    end else begin : g_next
      assign src_rem  = rem_s[k-1];
      assign src_root = root_s[k-1];
      assign src_tag  = tag_s[k-1];
      assign src_vld  = vld[k-1];
    end

    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        trial[l] = (IN_W'(src_root[l]) << (B + 1)) + (IN_W'(1) << (2 * B));
      end
    end

    always_ff @(posedge clk) begin
      for (int l = 0; l < LANES; l++) begin
        if (src_rem[l] >= trial[l]) begin
          rem_s[k][l]  <= src_rem[l] - trial[l];
          root_s[k][l] <= src_root[l] | (RW'(1) << B);
        end else begin
          rem_s[k][l]  <= src_rem[l];
          root_s[k][l] <= src_root[l];
        end
      end
      tag_s[k] <= src_tag;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else begin
        vld[k] <= src_vld;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < LANES; l++) begin
      out_root[l] <= root_s[RW-1][l]
                   + RW'(ROUND && (rem_s[RW-1][l] > IN_W'(root_s[RW-1][l])));
    end
    out_tag <= tag_s[RW-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= vld[RW-1];
    end
  end

endmodule
`default_nettype wire

>>> rtl/edc_div.sv
// Pipelined restoring divider, one quotient bit per stage, several lanes.
// Standalone; the caller guarantees the starting remainder is below the divisor.
`default_nettype none
module edc_div #(
  parameter int LANES = 1,
  parameter int QW    = 31,
  parameter int DW    = 32,
  parameter int TW    = 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic [LANES-1:0][DW-1:0]    in_rem,
  input  logic [LANES-1:0][QW-1:0]    in_low,
  input  logic [LANES-1:0][DW-1:0]    in_den,
  input  logic [TW-1:0]               in_tag,
  output logic                        out_valid,
  output logic [LANES-1:0][QW-1:0]    out_quo,
  output logic [TW-1:0]               out_tag
);
  logic [LANES-1:0][DW-1:0] rem_s [QW];
  logic [LANES-1:0][QW-1:0] low_s [QW];
  logic [LANES-1:0][DW-1:0] den_s [QW];
  logic [LANES-1:0][QW-1:0] quo_s [QW];
  logic [TW-1:0]            tag_s [QW];
  logic                     vld   [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int B = QW - 1 - k;
    logic [LANES-1:0][DW-1:0] src_rem;
    logic [LANES-1:0][QW-1:0] src_low;
    logic [LANES-1:0][DW-1:0] src_den;
    logic [LANES-1:0][QW-1:0] src_quo;
    logic [TW-1:0]            src_tag;
    logic                     src_vld;
    logic [LANES-1:0][DW:0]   rem2;

    if (k == 0) begin : g_first
      assign src_rem = in_rem;
      assign src_low = in_low;
      assign src_den = in_den;
      assign src_quo = '0;
      assign src_tag = in_tag;
      assign src_vld = in_valid;
    end else begin : g_next
      assign src_rem = rem_s[k-1];
      assign src_low = low_s[k-1];
      assign src_den = den_s[k-1];
      assign src_quo = quo_s[k-1];
      assign src_tag = tag_s[k-1];
      assign src_vld = vld[k-1];
    end

    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        rem2[l] = {src_rem[l], src_low[l][B]};
      end
    end

    always_ff @(posedge clk) begin
      for (int l = 0; l < LANES; l++) begin
        if (rem2[l] >= {1'b0, src_den[l]}) begin
          rem_s[k][l] <= DW'(rem2[l] - {1'b0, src_den[l]});
          quo_s[k][l] <= src_quo[l] | (QW'(1) << B);
        end else begin
          rem_s[k][l] <= DW'(rem2[l]);
          quo_s[k][l] <= src_quo[l];
        end
      end
      low_s[k] <= src_low;
      den_s[k] <= src_den;
      tag_s[k] <= src_tag;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else begin
        vld[k] <= src_vld;
      end
    end
  end

  assign out_valid = vld[QW-1];
  assign out_quo   = quo_s[QW-1];
  assign out_tag   = tag_s[QW-1];

endmodule
`default_nettype wire

>>> rtl/edc_norm.sv
// Eigenvector scaling: magnitudes, leading-one search, block shift, squares and sum.
// Depends on edc_pkg; handles both vectors of one item per beat.
`default_nettype none
module edc_norm import edc_pkg::*; #(
  parameter int TW = 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  vec_t [1:0]                  in_vec,
  input  logic [TW-1:0]               in_tag,
  output logic                        out_valid,
  output mag_t [1:0][3:0]             out_mag,
  output logic [1:0][3:0]             out_neg,
  output logic [1:0][SUM_W-1:0]       out_sum,
  output logic [TW-1:0]               out_tag
);
  localparam int PW = $clog2(CW);

  logic                       vld [NORM_LAT];
  logic [TW-1:0]              tag [NORM_LAT];

  logic [1:0][3:0][CW-1:0]    mag1, mag1_next, mag2;
  logic [1:0][3:0]            neg1, neg2, neg3, neg4;
  logic [1:0][CW-1:0]         orv1, orv1_next;
  logic [1:0][PW-1:0]         pos2, pos2_next;
  mag_t [1:0][3:0]            mag3, mag3_next, mag4;
  logic [1:0][3:0][2*MW-1:0]  sq4;

  always_comb begin
    for (int v = 0; v < 2; v++) begin
      orv1_next[v] = '0;
      for (int c = 0; c < 4; c++) begin
        mag1_next[v][c] = in_vec[v][c][CW-1] ? CW'(-in_vec[v][c]) : CW'(in_vec[v][c]);
        orv1_next[v]    = orv1_next[v] | mag1_next[v][c];
      end
    end
  end

  always_comb begin
    for (int v = 0; v < 2; v++) begin
      pos2_next[v] = '0;
      for (int i = 0; i < CW; i++) begin
        if (orv1[v][i]) begin
          pos2_next[v] = PW'(i);
        end
      end
    end
  end

  always_comb begin
    logic [CW-1:0] sh;
    for (int v = 0; v < 2; v++) begin
      for (int c = 0; c < 4; c++) begin
        if (pos2[v] > PW'(VFB)) begin
          sh = mag2[v][c] >> (pos2[v] - PW'(VFB));
        end else begin
          sh = mag2[v][c] << (PW'(VFB) - pos2[v]);
        end
        mag3_next[v][c] = sh[MW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int v = 0; v < 2; v++) begin
      for (int c = 0; c < 4; c++) begin
        neg1[v][c] <= in_vec[v][c][CW-1];
        sq4[v][c]  <= (2*MW)'(mag3[v][c]) * (2*MW)'(mag3[v][c]);
      end
      out_sum[v] <= SUM_W'(sq4[v][0]) + SUM_W'(sq4[v][1])
                  + SUM_W'(sq4[v][2]) + SUM_W'(sq4[v][3]);
    end
    mag1    <= mag1_next;
    orv1    <= orv1_next;
    mag2    <= mag1;
    pos2    <= pos2_next;
    neg2    <= neg1;
    mag3    <= mag3_next;
    neg3    <= neg2;
    mag4    <= mag3;
    neg4    <= neg3;
    out_mag <= mag4;
    out_neg <= neg4;
    tag[0]  <= in_tag;
    for (int s = 1; s < NORM_LAT; s++) begin
      tag[s] <= tag[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < NORM_LAT; s++) begin
        vld[s] <= 1'b0;
      end
    end else begin
      vld[0] <= in_valid;
      for (int s = 1; s < NORM_LAT; s++) begin
        vld[s] <= vld[s-1];
      end
    end
  end

  assign out_valid = vld[NORM_LAT-1];
  assign out_tag   = tag[NORM_LAT-1];

endmodule
`default_nettype wire

>>> rtl/eigen_decomposition_2x2_top.sv
// Top level of the closed-form 2x2 eigen decomposition pipeline.
// Depends on edc_pkg, edc_isqrt, edc_div and edc_norm.
//
// Usage:
//   One real 2x2 matrix (mat, four signed Q16.16 entries) is taken per beat
//   when start is high and busy is low. busy is always low: a new matrix may
//   enter on every clock cycle.
//   Each matrix yields one result beat on res, marked by done for exactly one
//   cycle: both eigenvalues (Q16.16, saturated) and one unit eigenvector per
//   eigenvalue (complex components in Q2.30).
//   The pipeline holds the 34-stage discriminant root, the 32-stage norm root and
//   the 31-stage quotient divider, plus the product, scaling and output stages.
//   Throughput is one matrix per cycle; results leave in input order.
//   The receiver cannot hold results off, so nothing inside ever stalls.
//   Synchronous reset (rst) drops every beat in flight; no result appears
//   for a matrix accepted before reset.
`default_nettype none
module eigen_decomposition_2x2_top import edc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  input  edc_in_t  mat,
  output logic     done,
  output edc_out_t res
);
  localparam int ETW = DW + 1;
  localparam int LAT = 4 + (SW + 1) + 1 + NORM_LAT + (NW + 1) + 1 + MW + 1;
  localparam logic signed [LW-1:0] SAT_HI = {{(LW-DW+1){1'b0}}, {(DW-1){1'b1}}};
  localparam logic signed [LW-1:0] SAT_LO = ~SAT_HI;

  typedef struct packed {
    logic signed [ETW-1:0] tr;
    logic signed [ETW-1:0] df;
    logic signed [DW-1:0]  a21;
    logic signed [DW-1:0]  a12;
    logic                  cplx;
  } front_t;

  typedef struct packed {
    lam_t                  lam;
    mag_t [1:0][3:0]       mag;
    logic [1:0][3:0]       neg;
  } ntag_t;

  typedef struct packed {
    lam_t                  lam;
    logic [1:0][3:0]       neg;
  } dtag_t;

  function automatic logic signed [DW-1:0] sat_lam(input logic signed [LW-1:0] x);
    if (x > SAT_HI) begin
      return SAT_HI[DW-1:0];
    end else if (x < SAT_LO) begin
      return SAT_LO[DW-1:0];
    end
    return x[DW-1:0];
  endfunction

  assign busy = 1'b0;

  // front end: trace, difference, discriminant
  logic                      v1, v2, v3, v4;
  logic signed [ETW-1:0]     tr1, df1, tr2, df2, tr3, df3;
  logic signed [2*DW-1:0]    pq1, pq2;
  logic signed [2*ETW-1:0]   dsq2;
  logic signed [2*ETW:0]     disc3;
  logic signed [DW-1:0]      a21_1, a12_1, a21_2, a12_2, a21_3, a12_3;
  logic [0:0][DISC_W-1:0]    dmag4;
  front_t                    fr4;

  always_ff @(posedge clk) begin
    tr1   <= ETW'(mat.m11) + ETW'(mat.m22);
    df1   <= ETW'(mat.m11) - ETW'(mat.m22);
    pq1   <= (2*DW)'(mat.m12) * (2*DW)'(mat.m21);
    a21_1 <= mat.m21;
    a12_1 <= mat.m12;

    dsq2  <= (2*ETW)'(df1) * (2*ETW)'(df1);
    pq2   <= pq1;
    tr2   <= tr1;
    df2   <= df1;
    a21_2 <= a21_1;
    a12_2 <= a12_1;

    disc3 <= (2*ETW+1)'(dsq2) + ((2*ETW+1)'(pq2) <<< 2);
    tr3   <= tr2;
    df3   <= df2;
    a21_3 <= a21_2;
    a12_3 <= a12_2;

    dmag4[0] <= disc3[2*ETW] ? DISC_W'(-disc3) : DISC_W'(disc3);
    fr4.tr   <= tr3;
    fr4.df   <= df3;
    fr4.a21  <= a21_3;
    fr4.a12  <= a12_3;
    fr4.cplx <= disc3[2*ETW];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= start && !busy;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  // rounded root of |disc|
  logic                 sq_valid;
  logic [0:0][SW-1:0]   sq_root;
  front_t               sq_fr;

  edc_isqrt #(
    .IN_W  (DISC_W),
    .LANES (1),
    .TW    ($bits(front_t)),
    .ROUND (1'b1)
  ) u_disc_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v4),
    .in_rad    (dmag4),
    .in_tag    (fr4),
    .out_valid (sq_valid),
    .out_root  (sq_root),
    .out_tag   (sq_fr)
  );

  // eigenvalues and raw eigenvectors at twice scale
  logic        v5;
  lam_t        lam5, lam5_next;
  vec_t [1:0]  vec5, vec5_next;

  always_comb begin
    comp_t s36, tr36, df36, two21, two12;
    s36   = comp_t'({{(CW-SW){1'b0}}, sq_root[0]});
    tr36  = comp_t'(sq_fr.tr);
    df36  = comp_t'(sq_fr.df);
    two21 = comp_t'(sq_fr.a21) <<< 1;
    two12 = comp_t'(sq_fr.a12) <<< 1;

    if (sq_fr.cplx) begin
      lam5_next.l1 = LW'((tr36 + 36'sd1) >>> 1);
      lam5_next.l2 = LW'((tr36 + 36'sd1) >>> 1);
      lam5_next.im = IMW'(((SW+1)'(sq_root[0]) + (SW+1)'(1)) >> 1);
    end else begin
      lam5_next.l1 = LW'((tr36 + s36 + 36'sd1) >>> 1);
      lam5_next.l2 = LW'((tr36 - s36 + 36'sd1) >>> 1);
      lam5_next.im = '0;
    end

    vec5_next = '0;
    if (sq_fr.a21 != '0) begin
      vec5_next[0][2] = two21;
      vec5_next[1][2] = two21;
      if (sq_fr.cplx) begin
        vec5_next[0][0] = df36;
        vec5_next[0][1] = s36;
        vec5_next[1][0] = df36;
        vec5_next[1][1] = -s36;
      end else begin
        vec5_next[0][0] = df36 + s36;
        vec5_next[1][0] = df36 - s36;
      end
    end else if (sq_fr.a12 != '0) begin
      vec5_next[0][0] = two12;
      vec5_next[1][0] = two12;
      if (sq_fr.cplx) begin
        vec5_next[0][2] = -df36;
        vec5_next[0][3] = s36;
        vec5_next[1][2] = -df36;
        vec5_next[1][3] = -s36;
      end else begin
        vec5_next[0][2] = s36 - df36;
        vec5_next[1][2] = -df36 - s36;
      end
    end else begin
      vec5_next[0][0] = 36'sd1;
      vec5_next[1][2] = 36'sd1;
    end
  end

  always_ff @(posedge clk) begin
    lam5 <= lam5_next;
    vec5 <= vec5_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else begin
      v5 <= sq_valid;
    end
  end

  // scaling and sum of squares
  logic                   nm_valid;
  mag_t [1:0][3:0]        nm_mag;
  logic [1:0][3:0]        nm_neg;
  logic [1:0][SUM_W-1:0]  nm_sum;
  lam_t                   nm_lam;
  ntag_t                  nt_in;

  edc_norm #(
    .TW ($bits(lam_t))
  ) u_norm (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v5),
    .in_vec    (vec5),
    .in_tag    (lam5),
    .out_valid (nm_valid),
    .out_mag   (nm_mag),
    .out_neg   (nm_neg),
    .out_sum   (nm_sum),
    .out_tag   (nm_lam)
  );

  assign nt_in.lam = nm_lam;
  assign nt_in.mag = nm_mag;
  assign nt_in.neg = nm_neg;

  logic                n_valid;
  logic [1:0][NW-1:0]  n_root;
  ntag_t               nt_out;

  edc_isqrt #(
    .IN_W  (SUM_W),
    .LANES (2),
    .TW    ($bits(ntag_t)),
    .ROUND (1'b0)
  ) u_norm_sqrt (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (nm_valid),
    .in_rad    (nm_sum),
    .in_tag    (nt_in),
    .out_valid (n_valid),
    .out_root  (n_root),
    .out_tag   (nt_out)
  );

  // dividend with half-divisor rounding
  logic                     v6;
  logic [7:0][NUM_W-1:0]    num6;
  logic [7:0][NW-1:0]       den6;
  logic [7:0][NW-1:0]       rem6;
  logic [7:0][MW-1:0]       low6;
  dtag_t                    dt6;

  always_ff @(posedge clk) begin
    for (int v = 0; v < 2; v++) begin
      for (int c = 0; c < 4; c++) begin
        num6[v*4+c] <= (NUM_W'(nt_out.mag[v][c]) << VFB) + NUM_W'(n_root[v] >> 1);
        den6[v*4+c] <= n_root[v];
      end
    end
    dt6.lam <= nt_out.lam;
    dt6.neg <= nt_out.neg;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v6 <= 1'b0;
    end else begin
      v6 <= n_valid;
    end
  end

  always_comb begin
    for (int l = 0; l < 8; l++) begin
      rem6[l] = NW'(num6[l][NUM_W-1:MW]);
      low6[l] = num6[l][MW-1:0];
    end
  end

  logic               dv_valid;
  logic [7:0][MW-1:0] dv_quo;
  dtag_t              dv_tag;

  edc_div #(
    .LANES (8),
    .QW    (MW),
    .DW    (NW),
    .TW    ($bits(dtag_t))
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v6),
    .in_rem    (rem6),
    .in_low    (low6),
    .in_den    (den6),
    .in_tag    (dt6),
    .out_valid (dv_valid),
    .out_quo   (dv_quo),
    .out_tag   (dv_tag)
  );

  // output register: saturation and signs
  logic signed [DW-1:0] comp_next [8];
  logic        [DW-2:0] im_sat;

  always_comb begin
    for (int l = 0; l < 8; l++) begin
      comp_next[l] = dv_tag.neg[l/4][l%4] ? -DW'(dv_quo[l]) : DW'(dv_quo[l]);
    end
    if (dv_tag.lam.im > IMW'({(DW-1){1'b1}})) begin
      im_sat = {(DW-1){1'b1}};
    end else begin
      im_sat = dv_tag.lam.im[DW-2:0];
    end
  end

  always_ff @(posedge clk) begin
    res.lam1_re   <= sat_lam(dv_tag.lam.l1);
    res.lam2_re   <= sat_lam(dv_tag.lam.l2);
    res.lam1_im   <= im_sat;
    res.lam2_im   <= -$signed({1'b0, im_sat});
    res.vec1_x_re <= comp_next[0];
    res.vec1_x_im <= comp_next[1];
    res.vec1_y_re <= comp_next[2];
    res.vec1_y_im <= comp_next[3];
    res.vec2_x_re <= comp_next[4];
    res.vec2_x_im <= comp_next[5];
    res.vec2_y_re <= comp_next[6];
    res.vec2_y_im <= comp_next[7];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= dv_valid;
    end
  end

  a_latency: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##(LAT) done)
    else $error("result beat missing at fixed latency");

  a_conj: assert property (@(posedge clk) disable iff (rst)
    done |-> res.lam2_im == -$signed({1'b0, res.lam1_im}))
    else $error("eigenvalue imaginary parts are not conjugate");

  a_pair: assert property (@(posedge clk) disable iff (rst)
    done && res.lam1_im != '0 |-> res.lam1_re == res.lam2_re)
    else $error("complex pair with differing real parts");

endmodule
`default_nettype wire

>>> test/edc_checker.sv
// Checker for the 2x2 eigen decomposition block: predicts each result from the
// accepted matrix and compares it with the done beat. Depends on edc_pkg.
module edc_checker import edc_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  logic     busy,
  input  edc_in_t  mat,
  input  logic     done,
  input  edc_out_t res,
  output int       errors,
  output int       pending,
  output int       n_results
);
  timeunit 1ns;
  timeprecision 1ps;

  edc_out_t eig_q[$];

  function automatic logic [127:0] root_round(logic [127:0] d);
    logic [127:0] r, t;
    r = 0;
    for (int b = 40; b >= 0; b--) begin
      t = r | (128'd1 << b);
      if (t * t <= d) r = t;
    end
    if (d - r * r > r) r++;
    return r;
  endfunction

  function automatic longint floor_half(longint x);
    return x >>> 1;
  endfunction

  function automatic longint clamp32(longint x);
    if (x > 64'sd2147483647) return 64'sd2147483647;
    if (x < -64'sd2147483648) return -64'sd2147483648;
    return x;
  endfunction

  function automatic void unit_vec(input longint v[4], output longint o[4]);
    logic [63:0] mag[4];
    logic [63:0] top, sum, n, r, t, q;
    top = 0;
    for (int i = 0; i < 4; i++) begin
      mag[i] = v[i] < 0 ? -v[i] : v[i];
      if (mag[i] > top) top = mag[i];
    end
    if (top == 0) begin
      for (int i = 0; i < 4; i++) o[i] = 0;
      return;
    end
    while (top >= 64'd1 << 31) begin
      for (int i = 0; i < 4; i++) mag[i] >>= 1;
      top >>= 1;
    end
    while (top < 64'd1 << 30) begin
      for (int i = 0; i < 4; i++) mag[i] <<= 1;
      top <<= 1;
    end
    sum = 0;
    for (int i = 0; i < 4; i++) sum += mag[i] * mag[i];
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= sum) r = t;
    end
    n = r == 0 ? 1 : r;
    for (int i = 0; i < 4; i++) begin
      q = ((mag[i] << 30) + (n >> 1)) / n;
      o[i] = v[i] < 0 ? -longint'(q) : longint'(q);
    end
  endfunction

  function automatic edc_out_t eigen_of(edc_in_t m);
    longint a11, a21, a12, a22, tr, df, s, l1, l2, im;
    longint v1[4], v2[4], u1[4], u2[4];
    logic signed [127:0] disc;
    logic cpx;
    edc_out_t o;
    a11 = m.m11; a21 = m.m21; a12 = m.m12; a22 = m.m22;
    tr = a11 + a22;
    df = a11 - a22;
    disc = 128'(df) * 128'(df) + 128'sd4 * 128'(a12) * 128'(a21);
    cpx = disc < 0;
    s = longint'(root_round(cpx ? -disc : disc));
    im = 0;
    if (cpx) begin
      l1 = clamp32(floor_half(tr + 1));
      l2 = l1;
      im = floor_half(s + 1);
      if (im > 64'sd2147483647) im = 64'sd2147483647;
    end else begin
      l1 = clamp32(floor_half(tr + s + 1));
      l2 = clamp32(floor_half(tr - s + 1));
    end
    if (a21 != 0) begin
      v1[2] = 2 * a21; v2[2] = 2 * a21; v1[3] = 0; v2[3] = 0;
      if (cpx) begin
        v1[0] = df; v1[1] = s; v2[0] = df; v2[1] = -s;
      end else begin
        v1[0] = df + s; v1[1] = 0; v2[0] = df - s; v2[1] = 0;
      end
    end else if (a12 != 0) begin
      v1[0] = 2 * a12; v2[0] = 2 * a12; v1[1] = 0; v2[1] = 0;
      if (cpx) begin
        v1[2] = -df; v1[3] = s; v2[2] = -df; v2[3] = -s;
      end else begin
        v1[2] = s - df; v1[3] = 0; v2[2] = -df - s; v2[3] = 0;
      end
    end else begin
      v1 = '{1, 0, 0, 0};
      v2 = '{0, 0, 1, 0};
    end
    unit_vec(v1, u1);
    unit_vec(v2, u2);
    o.lam1_re = l1[31:0];
    o.lam1_im = im[30:0];
    o.lam2_re = l2[31:0];
    o.lam2_im = 32'(-im);
    o.vec1_x_re = u1[0][31:0]; o.vec1_x_im = u1[1][31:0];
    o.vec1_y_re = u1[2][31:0]; o.vec1_y_im = u1[3][31:0];
    o.vec2_x_re = u2[0][31:0]; o.vec2_x_im = u2[1][31:0];
    o.vec2_y_re = u2[2][31:0]; o.vec2_y_im = u2[3][31:0];
    return o;
  endfunction

  initial begin
    errors = 0;
    n_results = 0;
  end

  assign pending = eig_q.size();

  always @(posedge clk) begin
    edc_out_t want;
    if (!rst && done) begin
      n_results <= n_results + 1;
      if (eig_q.size() == 0) begin
        errors <= errors + 1;
        if (errors < 10) $display("unexpected result beat: %h", res);
      end else begin
        want = eig_q.pop_front();
        if (res !== want) begin
          errors <= errors + 1;
          if (errors < 10)
            $display("mismatch: exp %h\n          got %h", want, res);
        end
      end
    end
    if (!rst && start && !busy) eig_q.push_back(eigen_of(mat));
  end
endmodule

>>> test/tb.sv
// Top of the testbench: drives matrices into the eigen decomposition block,
// gives the verdict. Depends on edc_pkg, edc_checker and the RTL top.
module tb import edc_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 0, rst = 1, start = 0;
  logic busy, done;
  edc_in_t mat = '0;
  edc_out_t res;
  int errors, pending, n_results;
  int n_items = 0;

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  eigen_decomposition_2x2_top dut (.*);
  edc_checker chk (.*);

  function automatic logic [31:0] pick_entry();
    case ($urandom_range(0, 9))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return 0;
      3, 4: return $urandom_range(0, 1) ? $urandom_range(0, 255) << 16
                                        : -($urandom_range(0, 255) << 16);
      5, 6: return 32'($signed($urandom_range(0, 65535)) - 32768);
      default: return $urandom;
    endcase
  endfunction

  task automatic send(edc_in_t m);
    mat <= m;
    start <= 1;
    do @(posedge clk); while (busy);
    @(negedge clk);
    n_items++;
  endtask

  task automatic idle(int n);
    start <= 0;
    repeat (n) @(negedge clk);
  endtask

  initial begin
    edc_in_t m;
    logic [31:0] ext[4];
    int burst;
    ext = '{32'h7fffffff, 32'h80000000, 0, 32'h00010000};
    repeat (9) @(negedge clk);
    rst <= 0;
    @(negedge clk);
    for (int i = 0; i < 16; i++) begin
      m.m11 = ext[i % 4]; m.m21 = ext[(i / 4) % 4];
      m.m12 = ext[(i + 1) % 4]; m.m22 = ext[(i + 2) % 4];
      send(m);
    end
    send('{32'h00010000, 0, 0, 32'h00020000});       // diagonal
    send('{32'h00010000, 0, 32'h00030000, 32'h00020000}); // upper triangular
    send('{0, 32'hffff0000, 32'h00010000, 0});       // rotation, complex pair
    send('{32'h00020000, 32'h00010000, 32'h00010000, 32'h00020000});
    send('{32'h00010000, 0, 32'h00010000, 32'h00010000}); // defective
    send('{32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff});
    send('{32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff});
    send('{32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h7fffffff});
    idle(0);
    while (pending != 0) @(negedge clk);
    while (n_items < 1100) begin
      burst = $urandom_range(1, 40);
      repeat (burst) begin
        m.m11 = pick_entry(); m.m21 = pick_entry();
        m.m12 = pick_entry(); m.m22 = pick_entry();
        if ($urandom_range(0, 7) == 0) m.m21 = 0;
        if ($urandom_range(0, 7) == 0) begin
          m.m21 = 0; m.m12 = 0;
        end
        send(m);
      end
      if ($urandom_range(0, 2) == 0) idle($urandom_range(1, 150));
    end
    idle(0);
    while (pending != 0) @(negedge clk);
    repeat (150) @(negedge clk);
    $display("Sent %0d matrices, checked %0d results (real, complex, triangular, diagonal).",
             n_items, n_results);
    if (errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end
endmodule

>>> filelist.f
rtl/edc_pkg.sv
rtl/edc_isqrt.sv
rtl/edc_div.sv
rtl/edc_norm.sv
rtl/eigen_decomposition_2x2_top.sv
test/edc_checker.sv
test/tb.sv
